// ----- src/dscc_pkg.sv -----
// Shared types, constants and SipHash round functions for the server cookie checker.
package dscc_pkg;

  // Cookie sizes in bytes.
  localparam int unsigned CcookieLen = 8;
  localparam int unsigned ScookieLen = 8;
  localparam int unsigned MsgBytes   = 16 + CcookieLen;

  // Key lanes: previous, current and following key.
  localparam int unsigned NumLanes  = 3;
  localparam int unsigned LanePrev  = 0;
  localparam int unsigned LaneCur   = 1;
  localparam int unsigned LaneNext  = 2;

  // Two compression rounds per message word, two for the length word, four to finish.
  localparam int unsigned NumRounds = 12;

  // Cookie length at which a presented server cookie may be valid.
  localparam logic [5:0] ValidCookieLen = 6'(CcookieLen + ScookieLen);

  // SipHash initialization constants.
  localparam logic [63:0] SipInit0 = 64'h736f6d6570736575;
  localparam logic [63:0] SipInit1 = 64'h646f72616e646f6d;
  localparam logic [63:0] SipInit2 = 64'h6c7967656e657261;
  localparam logic [63:0] SipInit3 = 64'h7465646279746573;

  // Final block: message length in the top byte, no tail bytes.
  localparam logic [63:0] LenWord   = {8'(MsgBytes), 56'd0};
  localparam logic [63:0] FinalMark = 64'h00000000000000ff;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    RegPrevLow  = 3'd0,
    RegPrevHigh = 3'd1,
    RegCurLow   = 3'd2,
    RegCurHigh  = 3'd3,
    RegNextLow  = 3'd4,
    RegNextHigh = 3'd5
  } dscc_reg_e;

  // One SipHash state: v0 to v3.
  typedef logic [3:0][63:0] sip_v_t;

  // Key pair for one lane.
  typedef struct packed {
    logic [63:0] k1;
    logic [63:0] k0;
  } dscc_key_t;

  typedef dscc_key_t [NumLanes-1:0] dscc_keys_t;

  // Everything that travels down the round pipeline with an item.
  typedef struct packed {
    sip_v_t [NumLanes-1:0] v;
    logic [63:0]           m0;
    logic [63:0]           m1;
    logic [63:0]           m2;
    logic [63:0]           sc;
    logic                  len_ok;
  } dscc_stage_t;

  function automatic logic [63:0] rotl64(input logic [63:0] x, input int unsigned s);
    return (x << s) | (x >> (64 - s));
  endfunction

  // One SipRound on a full state.
  function automatic sip_v_t sip_round(input sip_v_t v);
    logic [63:0] v0;
    logic [63:0] v1;
    logic [63:0] v2;
    logic [63:0] v3;
    sip_v_t      r;
    v0 = v[0];
    v1 = v[1];
    v2 = v[2];
    v3 = v[3];
    v0 = v0 + v1; v1 = rotl64(v1, 13); v1 = v1 ^ v0; v0 = rotl64(v0, 32);
    v2 = v2 + v3; v3 = rotl64(v3, 16); v3 = v3 ^ v2;
    v0 = v0 + v3; v3 = rotl64(v3, 21); v3 = v3 ^ v0;
    v2 = v2 + v1; v1 = rotl64(v1, 17); v1 = v1 ^ v2; v2 = rotl64(v2, 32);
    r[0] = v0;
    r[1] = v1;
    r[2] = v2;
    r[3] = v3;
    return r;
  endfunction

  // Word folded into v3 ahead of round r.
  function automatic logic [63:0] pre_word(input dscc_stage_t d, input int unsigned r);
    logic [63:0] w;
    case (r)
      0:       w = d.m0;
      2:       w = d.m1;
      4:       w = d.m2;
      6:       w = LenWord;
      default: w = '0;
    endcase
    return w;
  endfunction

  // Word folded into v0 after round r.
  function automatic logic [63:0] post_word(input dscc_stage_t d, input int unsigned r);
    logic [63:0] w;
    case (r)
      1:       w = d.m0;
      3:       w = d.m1;
      5:       w = d.m2;
      7:       w = LenWord;
      default: w = '0;
    endcase
    return w;
  endfunction

  // Finalization mark folded into v2 after the length word has been absorbed.
  function automatic logic [63:0] post_v2_word(input int unsigned r);
    return (r == 7) ? FinalMark : '0;
  endfunction

endpackage

// ----- src/dscc_query_if.sv -----
// Query channel: address, cookies and cookie length of one item.
interface dscc_query_if;
  logic        valid;
  logic        ready;
  logic        address_family;
  logic [63:0] addr_first_half;
  logic [63:0] addr_second_half;
  logic [63:0] client_cookie;
  logic [63:0] server_cookie_in;
  logic [5:0]  cookie_length;

  modport source (
    output valid, address_family, addr_first_half, addr_second_half,
    output client_cookie, server_cookie_in, cookie_length,
    input  ready
  );

  modport sink (
    input  valid, address_family, addr_first_half, addr_second_half,
    input  client_cookie, server_cookie_in, cookie_length,
    output ready
  );
endinterface

// ----- src/dscc_reply_if.sv -----
// Reply channel: echoed client cookie, new server cookie and check result of one item.
interface dscc_reply_if;
  logic        valid;
  logic        ready;
  logic [63:0] client_cookie_echo;
  logic [63:0] server_cookie_out;
  logic        cookie_valid;

  modport source (
    output valid, client_cookie_echo, server_cookie_out, cookie_valid,
    input  ready
  );

  modport sink (
    input  valid, client_cookie_echo, server_cookie_out, cookie_valid,
    output ready
  );
endinterface

// ----- src/dscc_key_regs.sv -----
// Key register file for the previous, current and following hour.
module dscc_key_regs import dscc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  output dscc_keys_t  keys_o
);

  dscc_keys_t keys_q;
  dscc_keys_t keys_d;

  // Decode the register index; indexes past the last key word are dropped.
  always_comb begin
    keys_d = keys_q;
    if (cfg_we_i) begin
      unique case (dscc_reg_e'(cfg_index_i))
        RegPrevLow:  keys_d[LanePrev].k0 = cfg_data_i;
        RegPrevHigh: keys_d[LanePrev].k1 = cfg_data_i;
        RegCurLow:   keys_d[LaneCur].k0  = cfg_data_i;
        RegCurHigh:  keys_d[LaneCur].k1  = cfg_data_i;
        RegNextLow:  keys_d[LaneNext].k0 = cfg_data_i;
        RegNextHigh: keys_d[LaneNext].k1 = cfg_data_i;
        default:     keys_d = keys_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keys_q <= '0;
    end else begin
      keys_q <= keys_d;
    end
  end

  assign keys_o = keys_q;

endmodule

// ----- src/dscc_round_stage.sv -----
// One SipRound pipeline stage for all three key lanes, with its valid bit and stall logic.
module dscc_round_stage import dscc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  dscc_stage_t data_i,
  output logic        ready_o,
  input  logic [63:0] pre_xor_i,
  input  logic [63:0] post_v0_xor_i,
  input  logic [63:0] post_v2_xor_i,
  output logic        valid_o,
  output dscc_stage_t data_o,
  input  logic        ready_i
);

  logic        valid_q;
  dscc_stage_t data_q;
  dscc_stage_t data_d;

  // The stage takes a new item when it is empty or its content moves on.
  assign ready_o = !valid_q || ready_i;

  // Absorb the scheduled word, run one round, then fold in the post words.
  always_comb begin
    sip_v_t lane_v;
    data_d = data_i;
    for (int l = 0; l < NumLanes; l++) begin
      lane_v    = data_i.v[l];
      lane_v[3] = lane_v[3] ^ pre_xor_i;
      lane_v    = sip_round(lane_v);
      lane_v[0] = lane_v[0] ^ post_v0_xor_i;
      lane_v[2] = lane_v[2] ^ post_v2_xor_i;
      data_d.v[l] = lane_v;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

`ifndef SYNTHESIS
  // A held item stays put while the next stage is full.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !ready_i |=> valid_q && $stable(data_q))
    else $error("round stage lost or changed a stalled item");

  // An item taken in shows up in the stage register in the following cycle.
  a_take_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && ready_o |=> valid_q)
    else $error("round stage dropped an incoming item");

  // An item that leaves with nothing behind it leaves a bubble, not a copy.
  a_leave_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && ready_i && !valid_i |=> !valid_q)
    else $error("round stage repeated an item");
`endif

endmodule

// ----- src/dscc_finish.sv -----
// Final stage: folds each lane's state into its hash, compares and registers the reply.
module dscc_finish import dscc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  dscc_stage_t         data_i,
  output logic                ready_o,
  dscc_reply_if.source        reply_o
);

  logic [NumLanes-1:0][63:0] hash;
  logic [NumLanes-1:0]       match;
  logic                      valid_q;
  logic [63:0]               echo_q;
  logic [63:0]               hash_q;
  logic                      ok_q;
  logic                      ok_d;

  assign ready_o = !valid_q || reply_o.ready;

  // Each lane's hash is the xor of its four state words.
  always_comb begin
    for (int l = 0; l < NumLanes; l++) begin
      hash[l]  = data_i.v[l][0] ^ data_i.v[l][1] ^ data_i.v[l][2] ^ data_i.v[l][3];
      match[l] = (hash[l] == data_i.sc);
    end
    ok_d = data_i.len_ok && (|match);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      echo_q <= data_i.m2;
      hash_q <= hash[LaneCur];
      ok_q   <= ok_d;
    end
  end

  assign reply_o.valid              = valid_q;
  assign reply_o.client_cookie_echo = echo_q;
  assign reply_o.server_cookie_out  = hash_q;
  assign reply_o.cookie_valid       = ok_q;

endmodule

// ----- src/dns_server_cookie_check_unit.sv -----
// Top level of the DNS server cookie checker: key registers, round pipeline and reply stage.
// Each query item is hashed with SipHash-2-4 over a 24-byte message (16 address bytes,
// IPv4 zero-filled, then the client cookie) under the previous, current and following
// keys in three parallel lanes. The twelve SipRounds of each lane are spread over twelve
// pipeline stages, one round per stage, behind an input stage that initializes the state
// and ahead of a reply stage that folds the hash and compares it with the presented
// server cookie. One item can be accepted every cycle while the reply side does not stall;
// every stage has its own valid bit, so a stalled reply only holds the stages that are full.
// The user must write keys through the configuration port only while no item is in flight;
// the block itself does not enforce this.
module dns_server_cookie_check_unit import dscc_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_index_i,
  input  logic [63:0]   cfg_data_i,
  dscc_query_if.sink    query_i,
  dscc_reply_if.source  reply_o
);

  dscc_keys_t  keys;

  logic        stage_valid [NumRounds+1];
  dscc_stage_t stage_data  [NumRounds+1];
  logic        stage_ready [NumRounds+2];

  logic        in_valid_q;
  dscc_stage_t in_data_q;
  dscc_stage_t in_data_d;

  dscc_key_regs u_key_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .keys_o      (keys)
  );

  // Input stage: build the message words and the initial state of every lane.
  always_comb begin
    in_data_d = '0;
    if (query_i.address_family) begin
      in_data_d.m0 = query_i.addr_first_half;
      in_data_d.m1 = query_i.addr_second_half;
    end else begin
      in_data_d.m0 = {32'd0, query_i.addr_first_half[31:0]};
      in_data_d.m1 = '0;
    end
    in_data_d.m2     = query_i.client_cookie;
    in_data_d.sc     = query_i.server_cookie_in;
    in_data_d.len_ok = (query_i.cookie_length == ValidCookieLen);
    for (int l = 0; l < NumLanes; l++) begin
      in_data_d.v[l][0] = keys[l].k0 ^ SipInit0;
      in_data_d.v[l][1] = keys[l].k1 ^ SipInit1;
      in_data_d.v[l][2] = keys[l].k0 ^ SipInit2;
      in_data_d.v[l][3] = keys[l].k1 ^ SipInit3;
    end
  end

  assign query_i.ready = stage_ready[0];
  assign stage_ready[0] = !in_valid_q || stage_ready[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (stage_ready[0]) begin
      in_valid_q <= query_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_ready[0]) begin
      in_data_q <= in_data_d;
    end
  end

  assign stage_valid[0] = in_valid_q;
  assign stage_data[0]  = in_data_q;

  // Round pipeline: stage r+1 runs SipRound r with its scheduled message words.
  for (genvar r = 0; r < NumRounds; r++) begin : g_round
    dscc_round_stage u_round (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .valid_i       (stage_valid[r]),
      .data_i        (stage_data[r]),
      .ready_o       (stage_ready[r+1]),
      .pre_xor_i     (pre_word(stage_data[r], r)),
      .post_v0_xor_i (post_word(stage_data[r], r)),
      .post_v2_xor_i (post_v2_word(r)),
      .valid_o       (stage_valid[r+1]),
      .data_o        (stage_data[r+1]),
      .ready_i       (stage_ready[r+2])
    );
  end

  // Reply stage.
  dscc_finish u_finish (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (stage_valid[NumRounds]),
    .data_i  (stage_data[NumRounds]),
    .ready_o (stage_ready[NumRounds+1]),
    .reply_o (reply_o)
  );

endmodule

// ----- test/dns_server_cookie_check_unit_tb.sv -----
// Self-checking testbench for the DNS server cookie checker: SipHash-2-4 prediction and reply checks.
`timescale 1ns / 100ps

module dns_server_cookie_check_unit_tb;
  import dscc_pkg::*;

  // Run length and timing figures.
  localparam int unsigned CycleLimit    = 1_000_000;
  localparam int unsigned PipeLatency   = 14;
  localparam int unsigned PhaseItems    = 320;
  localparam int unsigned RandomPhases  = 6;
  localparam int unsigned BurstItems    = 60;
  localparam int unsigned HoldOffCycles = 200;

  // Register indexes past the last key register; writes to them must be ignored.
  localparam logic [2:0] SpareRegLow  = 3'd6;
  localparam logic [2:0] SpareRegHigh = 3'd7;

  // One query item as the testbench sees it.
  typedef struct {
    logic        family;
    logic [63:0] addr_lo;
    logic [63:0] addr_hi;
    logic [63:0] client_cookie;
    logic [63:0] server_cookie;
    logic [5:0]  cookie_len;
  } query_t;

  // One reply item.
  typedef struct {
    logic [63:0] cookie_echo;
    logic [63:0] server_cookie;
    logic        cookie_ok;
  } reply_t;

  typedef logic [3:0][63:0] sip_state_t;

  logic clk;
  logic rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;

  dscc_query_if query_bus ();
  dscc_reply_if reply_bus ();

  dns_server_cookie_check_unit DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .query_i     (query_bus),
    .reply_o     (reply_bus)
  );

  // Shadow copy of the key registers, indexed like the configuration port.
  logic [63:0] key_regs [2*NumLanes];

  reply_t      pending_replies [$];
  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned queries_sent;
  int unsigned replies_checked;
  int unsigned cookies_accepted;
  int unsigned key_settings;
  bit          send_idle_on;
  bit          reply_idle_on;
  int unsigned reply_hold_request;

  // Free-running clock.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Watchdog on the whole run.
  initial begin : watchdog
    wait (cycle_count >= CycleLimit);
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic [63:0] rol64(input logic [63:0] x, input int unsigned n);
    return (x << n) | (x >> (64 - n));
  endfunction

  // One SipRound over the four state words.
  function automatic sip_state_t sip_mix(input sip_state_t s);
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
    logic [63:0] d;
    a = s[0];
    b = s[1];
    c = s[2];
    d = s[3];
    a = a + b; b = rol64(b, 13) ^ a; a = rol64(a, 32);
    c = c + d; d = rol64(d, 16) ^ c;
    a = a + d; d = rol64(d, 21) ^ a;
    c = c + b; b = rol64(b, 17) ^ c; c = rol64(c, 32);
    return {d, c, b, a};
  endfunction

  // SipHash-2-4 over a fixed three-word message.
  function automatic logic [63:0] siphash24(input logic [63:0] k0, input logic [63:0] k1,
                                            input logic [2:0][63:0] words);
    sip_state_t s;
    int         i;
    s[0] = k0 ^ SipInit0;
    s[1] = k1 ^ SipInit1;
    s[2] = k0 ^ SipInit2;
    s[3] = k1 ^ SipInit3;
    for (i = 0; i < 3; i++) begin
      s[3] = s[3] ^ words[i];
      s = sip_mix(sip_mix(s));
      s[0] = s[0] ^ words[i];
    end
    s[3] = s[3] ^ LenWord;
    s = sip_mix(sip_mix(s));
    s[0] = s[0] ^ LenWord;
    s[2] = s[2] ^ FinalMark;
    for (i = 0; i < 4; i++) s = sip_mix(s);
    return s[0] ^ s[1] ^ s[2] ^ s[3];
  endfunction

  // Hash of a query's message under one key lane; IPv4 keeps only the low 32 address bits.
  function automatic logic [63:0] lane_hash(input query_t q, input int unsigned lane);
    logic [2:0][63:0] words;
    words[0] = q.family ? q.addr_lo : {32'd0, q.addr_lo[31:0]};
    words[1] = q.family ? q.addr_hi : 64'd0;
    words[2] = q.client_cookie;
    return siphash24(key_regs[2*lane], key_regs[2*lane+1], words);
  endfunction

  // Expected reply: new cookie under the current key, valid only at length 16 on any match.
  function automatic reply_t predict_reply(input query_t q);
    reply_t      r;
    logic [63:0] h_prev;
    logic [63:0] h_cur;
    logic [63:0] h_next;
    h_prev = lane_hash(q, LanePrev);
    h_cur  = lane_hash(q, LaneCur);
    h_next = lane_hash(q, LaneNext);
    r.cookie_echo   = q.client_cookie;
    r.server_cookie = h_cur;
    r.cookie_ok     = (q.cookie_len > 6'(CcookieLen)) && (q.cookie_len == ValidCookieLen) &&
                      (q.server_cookie == h_prev || q.server_cookie == h_cur ||
                       q.server_cookie == h_next);
    return r;
  endfunction

  function automatic query_t make_query(input logic family, input logic [63:0] addr_lo,
                                        input logic [63:0] addr_hi, input logic [63:0] cc,
                                        input logic [63:0] sc, input logic [5:0] len);
    query_t q;
    q.family        = family;
    q.addr_lo       = addr_lo;
    q.addr_hi       = addr_hi;
    q.client_cookie = cc;
    q.server_cookie = sc;
    q.cookie_len    = len;
    return q;
  endfunction

  // Presents the hash under the given lane as the server cookie.
  function automatic query_t with_lane_cookie(input query_t q, input int unsigned lane);
    q.server_cookie = lane_hash(q, lane);
    return q;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Random word that now and then takes an extreme value.
  function automatic logic [63:0] rand_word();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return 64'd0;
    if (r < 16) return '1;
    return rand64();
  endfunction

  // Idle length: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Random query: length 16 in 45 percent of items, a matching lane cookie in 55 percent, the rest noise.
  function automatic query_t random_query();
    query_t      q;
    int unsigned r;
    q = make_query(1'($urandom_range(0, 1)), rand_word(), rand_word(), rand_word(), 64'd0,
                   6'd0);
    r = $urandom_range(0, 99);
    if (r < 45) q.cookie_len = ValidCookieLen;
    else if (r < 60) q.cookie_len = 6'(CcookieLen);
    else q.cookie_len = 6'($urandom_range(0, 63));
    r = $urandom_range(0, 99);
    if (r < 20) q = with_lane_cookie(q, LanePrev);
    else if (r < 40) q = with_lane_cookie(q, LaneCur);
    else if (r < 55) q = with_lane_cookie(q, LaneNext);
    else if (r < 70) begin
      q = with_lane_cookie(q, LaneCur);
      q.server_cookie = q.server_cookie ^ (64'd1 << $urandom_range(0, 63));
    end else q.server_cookie = rand_word();
    return q;
  endfunction

  // Offers one item and waits for its handshake; valid stays high for a back-to-back item.
  task automatic send_query(input query_t q);
    int unsigned gap;
    gap = send_idle_on ? pick_gap() : 0;
    if (gap != 0) begin
      query_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    query_bus.valid            <= 1'b1;
    query_bus.address_family   <= q.family;
    query_bus.addr_first_half  <= q.addr_lo;
    query_bus.addr_second_half <= q.addr_hi;
    query_bus.client_cookie    <= q.client_cookie;
    query_bus.server_cookie_in <= q.server_cookie;
    query_bus.cookie_length    <= q.cookie_len;
    @(posedge clk);
    while (!query_bus.ready) @(posedge clk);
    pending_replies.push_back(predict_reply(q));
    queries_sent++;
  endtask

  // Stops offering and waits until every expected reply has arrived.
  task automatic drain_replies();
    query_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  // One register write; the enable is lowered by the caller.
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    if (idx <= RegNextHigh) key_regs[idx] = data;
    @(posedge clk);
  endtask

  // Loads all three key pairs while idle, with stray writes to the unused indexes.
  task automatic load_keys(input logic [63:0] pk0, input logic [63:0] pk1,
                           input logic [63:0] ck0, input logic [63:0] ck1,
                           input logic [63:0] nk0, input logic [63:0] nk1);
    drain_replies();
    write_reg(RegPrevLow, pk0);
    write_reg(RegPrevHigh, pk1);
    write_reg(RegCurLow, ck0);
    write_reg(RegCurHigh, ck1);
    write_reg(RegNextLow, nk0);
    write_reg(RegNextHigh, nk1);
    write_reg(SpareRegLow, rand64());
    write_reg(SpareRegHigh, rand64());
    cfg_we <= 1'b0;
    @(posedge clk);
    key_settings++;
  endtask

  // Reply side: random stalls, plus long hold-offs on request.
  initial begin : reply_stall
    int unsigned stall_left;
    stall_left = 0;
    reply_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (reply_hold_request != 0) begin
        stall_left = reply_hold_request;
        reply_hold_request = 0;
      end
      if (!rst_n) begin
        reply_bus.ready <= 1'b0;
      end else if (stall_left != 0) begin
        reply_bus.ready <= 1'b0;
        stall_left--;
      end else begin
        reply_bus.ready <= 1'b1;
        if (reply_idle_on && $urandom_range(0, 99) < 25) stall_left = pick_gap();
      end
    end
  end

  // Reply checker: each accepted item against the oldest expectation.
  always @(posedge clk) begin
    reply_t want;
    if (rst_n && reply_bus.valid && reply_bus.ready) begin
      if (pending_replies.size() == 0) begin
        $error("unexpected reply item: echo %h cookie %h valid %b",
               reply_bus.client_cookie_echo, reply_bus.server_cookie_out,
               reply_bus.cookie_valid);
        error_count++;
      end else begin
        want = pending_replies.pop_front();
        if (reply_bus.client_cookie_echo !== want.cookie_echo) begin
          $error("client_cookie_echo: expected %h, actual %h", want.cookie_echo,
                 reply_bus.client_cookie_echo);
          error_count++;
        end
        if (reply_bus.server_cookie_out !== want.server_cookie) begin
          $error("server_cookie_out: expected %h, actual %h", want.server_cookie,
                 reply_bus.server_cookie_out);
          error_count++;
        end
        if (reply_bus.cookie_valid !== want.cookie_ok) begin
          $error("cookie_valid: expected %b, actual %b", want.cookie_ok,
                 reply_bus.cookie_valid);
          error_count++;
        end
        if (want.cookie_ok) cookies_accepted++;
        replies_checked++;
      end
    end
  end

  // Keys still at their reset value of zero: field extremes.
  task automatic test_reset_keys();
    send_query(make_query(1'b0, 64'd0, 64'd0, 64'd0, 64'd0, 6'(CcookieLen)));
    send_query(make_query(1'b1, '1, '1, '1, '1, ValidCookieLen));
    send_query(with_lane_cookie(make_query(1'b1, rand64(), rand64(), rand64(), 64'd0,
                                           ValidCookieLen), LaneCur));
    send_query(make_query(1'b0, '1, '1, rand64(), rand64(), 6'd63));
  endtask

  // Distinct keys: IPv4 masking, a match in each lane, a near miss and odd lengths.
  task automatic test_special_cases();
    logic [5:0] odd_lengths [9];
    query_t     q;
    odd_lengths = '{6'(CcookieLen), 6'd9, 6'd15, 6'd17, 6'd40, 6'd41, 6'd63, 6'd0, 6'd7};
    load_keys(rand64(), rand64(), rand64(), rand64(), rand64(), rand64());
    send_query(with_lane_cookie(make_query(1'b0, {32'hffff_ffff, $urandom}, '1, rand64(),
                                           64'd0, ValidCookieLen), LaneCur));
    send_query(with_lane_cookie(make_query(1'b1, rand64(), rand64(), rand64(), 64'd0,
                                           ValidCookieLen), LanePrev));
    send_query(with_lane_cookie(make_query(1'b1, rand64(), rand64(), rand64(), 64'd0,
                                           ValidCookieLen), LaneNext));
    q = with_lane_cookie(make_query(1'b1, rand64(), rand64(), rand64(), 64'd0,
                                    ValidCookieLen), LaneCur);
    q.server_cookie = q.server_cookie ^ (64'd1 << $urandom_range(0, 63));
    send_query(q);
    // A matching cookie must still be refused at every length other than 16.
    foreach (odd_lengths[i]) begin
      send_query(with_lane_cookie(make_query(1'($urandom_range(0, 1)), rand64(), rand64(),
                                             rand64(), 64'd0, odd_lengths[i]), LaneCur));
    end
  endtask

  // Extreme key values.
  task automatic test_extreme_keys();
    load_keys('1, '1, '1, '1, '1, '1);
    send_query(with_lane_cookie(make_query(1'b1, '1, '1, '1, 64'd0, ValidCookieLen),
                                LaneNext));
    send_query(make_query(1'b0, 64'd0, 64'd0, 64'd0, '1, ValidCookieLen));
    load_keys(64'd0, 64'd0, '1, '1, 64'h8000_0000_0000_0000, 64'd1);
    send_query(with_lane_cookie(make_query(1'b0, rand64(), rand64(), rand64(), 64'd0,
                                           ValidCookieLen), LanePrev));
    send_query(with_lane_cookie(make_query(1'b1, 64'd0, '1, rand64(), 64'd0,
                                           ValidCookieLen), LaneCur));
  endtask

  // Receiver holds off while the sender keeps offering, so the pipeline fills and stalls.
  task automatic test_reply_backpressure();
    drain_replies();
    send_idle_on       = 1'b0;
    reply_idle_on      = 1'b0;
    reply_hold_request = HoldOffCycles;
    repeat (BurstItems) send_query(random_query());
    drain_replies();
  endtask

  // Random traffic in phases, each under a new key setting, with the idle pattern varied across phases.
  task automatic test_random_traffic();
    logic [63:0] shared_k0;
    logic [63:0] shared_k1;
    for (int unsigned phase = 0; phase < RandomPhases; phase++) begin
      send_idle_on  = (phase == 1) || (phase >= 3);
      reply_idle_on = (phase == 2) || (phase >= 3);
      shared_k0 = rand64();
      shared_k1 = rand64();
      if (phase == 1) load_keys(shared_k0, shared_k1, shared_k0, shared_k1, shared_k0,
                                shared_k1);
      else if (phase == 2) load_keys(64'd0, 64'd0, '1, '1, rand64(), rand64());
      else load_keys(rand64(), rand64(), rand64(), rand64(), rand64(), rand64());
      repeat (PhaseItems) send_query(random_query());
      drain_replies();
    end
  endtask

  // Main sequence.
  initial begin
    rst_n                      <= 1'b0;
    cfg_we                     <= 1'b0;
    cfg_index                  <= RegPrevLow;
    cfg_data                   <= 64'd0;
    query_bus.valid            <= 1'b0;
    query_bus.address_family   <= 1'b0;
    query_bus.addr_first_half  <= 64'd0;
    query_bus.addr_second_half <= 64'd0;
    query_bus.client_cookie    <= 64'd0;
    query_bus.server_cookie_in <= 64'd0;
    query_bus.cookie_length    <= 6'd0;
    foreach (key_regs[i]) key_regs[i] = 64'd0;
    send_idle_on       = 1'b1;
    reply_idle_on      = 1'b1;
    reply_hold_request = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_keys();
    test_special_cases();
    test_extreme_keys();
    test_reply_backpressure();
    test_random_traffic();

    // Wait out the pipeline for any stray reply.
    drain_replies();
    repeat (2*PipeLatency) @(posedge clk);

    $display("Checked %0d of %0d query items under %0d key settings.", replies_checked,
             queries_sent, key_settings);
    $display("%0d server cookies were accepted, %0d refused; %0d mismatches.",
             cookies_accepted, replies_checked - cookies_accepted, error_count);
    if (error_count == 0 && pending_replies.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
